// ----- rtl/core/y2b_pkg.sv -----
// y2b_pkg: shared types, register indexes and color coefficients for the
// YUYV to bottom-up BGR converter. No dependencies.
package y2b_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_WIDTH_PAIRS  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;

  // Register reset values
  localparam logic [10:0] WIDTH_PAIRS_RST  = 11'd320;
  localparam logic [11:0] FRAME_HEIGHT_RST = 12'd480;

  // Hard caps on the counters (10-bit column, 11-bit row)
  localparam int COL_CAP = 1024;
  localparam int ROW_CAP = 2048;

  // Q16 coefficients, as signed constants for the chroma products
  localparam logic signed [17:0] KR  = 18'sd91881;   // 1.402
  localparam logic signed [17:0] KGU = 18'sd22554;   // 0.34414
  localparam logic signed [17:0] KGV = 18'sd46802;   // 0.71414
  localparam logic signed [17:0] KB  = 18'sd116130;  // 1.772

  // One YUYV macropixel
  typedef struct packed {
    logic [7:0] y0;
    logic [7:0] u;
    logic [7:0] y1;
    logic [7:0] v;
  } pix_t;

  // Position info captured with each beat, used to form the address
  typedef struct packed {
    logic [10:0] row_rev;  // h-1-row, row clamped
    logic [9:0]  col;      // column, clamped
    logic [10:0] width;    // effective width in pairs
    logic        row_end;
    logic        frame_end;
  } pos_t;

  // Floor of a Q16 sum, clipped to 0..255
  function automatic logic [7:0] clip_q16(input logic signed [27:0] s);
    logic [7:0] r;
    if (s[27]) begin
      r = 8'd0;
    end else if (|s[26:24]) begin
      r = 8'd255;
    end else begin
      r = s[23:16];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/y2b_pixel.sv -----
// y2b_pixel: converts one luma sample plus shared offset chroma to clipped BGR.
// Depends on y2b_pkg.
module y2b_pixel (
  input  logic [7:0]        y,
  input  logic signed [8:0] ur,
  input  logic signed [8:0] vr,
  output logic [7:0]        blue,
  output logic [7:0]        green,
  output logic [7:0]        red
);
  import y2b_pkg::*;

  logic signed [27:0] base;
  logic signed [27:0] b_sum;
  logic signed [27:0] g_sum;
  logic signed [27:0] r_sum;

  // Luma in Q16, kept signed so the chroma terms sign-extend
  assign base = $signed({4'd0, y, 16'd0});

  // Constant multiplies, one add for blue and red and two for green, then floor and clip
  assign b_sum = base + KB * ur;
  assign g_sum = base - KGU * ur - KGV * vr;
  assign r_sum = base + KR * vr;

  assign blue  = clip_q16(b_sum);
  assign green = clip_q16(g_sum);
  assign red   = clip_q16(r_sum);

endmodule

// ----- rtl/core/y2b_front.sv -----
// y2b_front: configuration registers, column/row counters and input register.
// Depends on y2b_pkg.
module y2b_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic [1:0]      cfg_index,
  input  logic [11:0]     cfg_data,
  input  logic            in_valid,
  output logic            in_ready,
  input  y2b_pkg::pix_t   in_pix,
  input  logic            back_ready,
  output logic            s1_valid,
  output y2b_pkg::pix_t   s1_pix,
  output y2b_pkg::pos_t   s1_pos
);
  import y2b_pkg::*;

  // Saturation limits derived from the size parameters
  localparam int WL0 = (MAX_WIDTH / 2 > COL_CAP) ? COL_CAP : MAX_WIDTH / 2;
  localparam int WL1 = (WL0 < 1) ? 1 : WL0;
  localparam int HL0 = (MAX_HEIGHT > ROW_CAP) ? ROW_CAP : MAX_HEIGHT;
  localparam int HL1 = (HL0 < 1) ? 1 : HL0;
  localparam logic [10:0] W_LIM = 11'(WL1);
  localparam logic [11:0] H_LIM = 12'(HL1);

  logic [10:0] width_pairs;
  logic [11:0] frame_height;
  logic [9:0]  pair_column;
  logic [10:0] source_row;
  logic [9:0]  pair_column_next;
  logic [10:0] source_row_next;

  logic [10:0] w_eff;
  logic [11:0] h_eff;
  logic [9:0]  col_cl;
  logic [10:0] row_cl;
  logic        rend;
  logic        fend;
  pos_t        pos;
  logic        accept;

  assign in_ready = !s1_valid || back_ready;
  assign accept   = in_valid && in_ready;

  // Effective size: zero reads as one, oversize saturates
  always_comb begin
    if (width_pairs == 11'd0) begin
      w_eff = 11'd1;
    end else if (width_pairs > W_LIM) begin
      w_eff = W_LIM;
    end else begin
      w_eff = width_pairs;
    end
    if (frame_height == 12'd0) begin
      h_eff = 12'd1;
    end else if (frame_height > H_LIM) begin
      h_eff = H_LIM;
    end else begin
      h_eff = frame_height;
    end
  end

  // Clamp counters for addressing, detect ends, step counters
  always_comb begin
    if ({1'b0, pair_column} >= w_eff) begin
      col_cl = 10'(w_eff - 11'd1);
    end else begin
      col_cl = pair_column;
    end
    if ({1'b0, source_row} >= h_eff) begin
      row_cl = 11'(h_eff - 12'd1);
    end else begin
      row_cl = source_row;
    end
    rend = ({1'b0, pair_column} + 11'd1) >= w_eff;
    fend = rend && (({1'b0, source_row} + 12'd1) >= h_eff);

    pair_column_next = pair_column;
    source_row_next  = source_row;
    if (rend) begin
      pair_column_next = 10'd0;
      if (fend) begin
        source_row_next = 11'd0;
      end else begin
        source_row_next = source_row + 11'd1;
      end
    end else begin
      pair_column_next = pair_column + 10'd1;
    end

    pos.row_rev   = 11'(h_eff - 12'd1 - {1'b0, row_cl});
    pos.col       = col_cl;
    pos.width     = w_eff;
    pos.row_end   = rend;
    pos.frame_end = fend;
  end

  // Control: config registers, counters, stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      width_pairs  <= WIDTH_PAIRS_RST;
      frame_height <= FRAME_HEIGHT_RST;
      pair_column  <= 10'd0;
      source_row   <= 11'd0;
      s1_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_WIDTH_PAIRS:  width_pairs  <= cfg_data[10:0];
          REG_FRAME_HEIGHT: frame_height <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        pair_column <= pair_column_next;
        source_row  <= source_row_next;
        s1_valid    <= 1'b1;
      end else if (back_ready) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // Input beat payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix <= in_pix;
      s1_pos <= pos;
    end
  end

endmodule

// ----- rtl/core/y2b_back.sv -----
// y2b_back: address multiply, two pixel converters and the result register.
// Depends on y2b_pkg and y2b_pixel.
module y2b_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            s1_valid,
  input  y2b_pkg::pix_t   s1_pix,
  input  y2b_pkg::pos_t   s1_pos,
  output logic            back_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [21:0]     dest_pixel_index,
  output logic [7:0]      blue_first,
  output logic [7:0]      green_first,
  output logic [7:0]      red_first,
  output logic [7:0]      blue_second,
  output logic [7:0]      green_second,
  output logic [7:0]      red_second,
  output logic            row_end,
  output logic            frame_end
);
  import y2b_pkg::*;

  logic signed [8:0] ur;
  logic signed [8:0] vr;
  logic [21:0] row_prod;
  logic [21:0] idx;
  logic [7:0]  b0, g0, r0, b1, g1, r1;
  logic        load;

  assign back_ready = !out_valid || out_ready;
  assign load       = s1_valid && back_ready;

  // Chroma minus 128, sign-extended
  assign ur = {~s1_pix.u[7], ~s1_pix.u[7], s1_pix.u[6:0]};
  assign vr = {~s1_pix.v[7], ~s1_pix.v[7], s1_pix.v[6:0]};

  // Bottom-up address: ((h-1-row)*w + col) * 2, mod 2^22
  assign row_prod = s1_pos.row_rev * s1_pos.width;
  assign idx      = {row_prod[20:0], 1'b0} + {11'd0, s1_pos.col, 1'b0};

  y2b_pixel u_pix_first (
    .y     (s1_pix.y0),
    .ur    (ur),
    .vr    (vr),
    .blue  (b0),
    .green (g0),
    .red   (r0)
  );

  y2b_pixel u_pix_second (
    .y     (s1_pix.y1),
    .ur    (ur),
    .vr    (vr),
    .blue  (b1),
    .green (g1),
    .red   (r1)
  );

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (back_ready) begin
      out_valid <= s1_valid;
    end
  end

  // Result beat payload
  always_ff @(posedge clk) begin
    if (load) begin
      dest_pixel_index <= idx;
      blue_first       <= b0;
      green_first      <= g0;
      red_first        <= r0;
      blue_second      <= b1;
      green_second     <= g1;
      red_second       <= r1;
      row_end          <= s1_pos.row_end;
      frame_end        <= s1_pos.frame_end;
    end
  end

endmodule

// ----- rtl/core/yuyv_to_bgr_bottom_up.sv -----
// yuyv_to_bgr_bottom_up: top level of the YUYV 4:2:2 to BGR 8:8:8 converter.
// Depends on y2b_pkg, y2b_front, y2b_back (and y2b_pixel below it).
//
// One YUYV macropixel beat in gives one result beat with two clipped BGR
// pixels, the first pixel's index in a bottom-up (BMP) frame buffer, and
// end-of-row / end-of-frame flags. The block takes a beat every clock
// while the result side is not stalled by out_ready; an input register that
// also snapshots the column/row counters feeds one pass of constant multiplies,
// the 11x11 address multiply and clipping into the result register. Size
// registers (index 0: width in pixel pairs, index 1: height in rows) should be
// written between frames; writes do not reset the counters.
module yuyv_to_bgr_bottom_up #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  luma_first,
  input  logic [7:0]  chroma_blue,
  input  logic [7:0]  luma_second,
  input  logic [7:0]  chroma_red,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [21:0] dest_pixel_index,
  output logic [7:0]  blue_first,
  output logic [7:0]  green_first,
  output logic [7:0]  red_first,
  output logic [7:0]  blue_second,
  output logic [7:0]  green_second,
  output logic [7:0]  red_second,
  output logic        row_end,
  output logic        frame_end
);
  import y2b_pkg::*;

  pix_t in_pix;
  pix_t s1_pix;
  pos_t s1_pos;
  logic s1_valid;
  logic back_ready;

  assign in_pix.y0 = luma_first;
  assign in_pix.u  = chroma_blue;
  assign in_pix.y1 = luma_second;
  assign in_pix.v  = chroma_red;

  y2b_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_pix     (in_pix),
    .back_ready (back_ready),
    .s1_valid   (s1_valid),
    .s1_pix     (s1_pix),
    .s1_pos     (s1_pos)
  );

  y2b_back u_back (
    .clk              (clk),
    .rst              (rst),
    .s1_valid         (s1_valid),
    .s1_pix           (s1_pix),
    .s1_pos           (s1_pos),
    .back_ready       (back_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .dest_pixel_index (dest_pixel_index),
    .blue_first       (blue_first),
    .green_first      (green_first),
    .red_first        (red_first),
    .blue_second      (blue_second),
    .green_second     (green_second),
    .red_second       (red_second),
    .row_end          (row_end),
    .frame_end        (frame_end)
  );

endmodule

// ----- tb/tb_yuyv_to_bgr_bottom_up.sv -----
`timescale 1ns / 1ps
// tb_yuyv_to_bgr_bottom_up: self-checking bench for the YUYV to bottom-up BGR converter.
// Depends on y2b_pkg and yuyv_to_bgr_bottom_up. A scoreboard class predicts each result
// beat from the accepted macropixels and the size registers.
module tb_yuyv_to_bgr_bottom_up;
  import y2b_pkg::*;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  // Indexes with no register behind them
  localparam logic [1:0] REG_UNUSED    = 2'd2;
  localparam logic [1:0] REG_UNUSED_HI = 2'd3;
  localparam int STALL_LIMIT = 1000;  // cycles without any beat before giving up
  localparam int PIPE_CYCLES = 4;     // settle time after the last result
  localparam int N_PHASES    = 10;
  localparam int N_CORNERS   = 12;

  typedef struct packed {
    logic [21:0] dest;
    logic [7:0]  blue0, green0, red0, blue1, green1, red1;
    logic        row_end, frame_end;
  } bgr_pair_t;

  // Predicts the converter and checks its result beats in order
  class pair_scoreboard;
    logic [10:0] width_reg;
    logic [11:0] height_reg;
    int          col, row;
    bgr_pair_t   expected_pairs[$];
    int          errors;
    int          beats_out;

    function new();
      width_reg  = WIDTH_PAIRS_RST;
      height_reg = FRAME_HEIGHT_RST;
      col        = 0;
      row        = 0;
      errors     = 0;
      beats_out  = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [11:0] data);
      case (idx)
        REG_WIDTH_PAIRS: begin
          width_reg = data[10:0];
        end
        REG_FRAME_HEIGHT: begin
          height_reg = data;
        end
        default: begin
        end
      endcase
    endfunction

    // Floor of a Q16 sum, clipped to a byte
    function logic [7:0] shade(int luma, int chroma_term);
      int s;
      s = (luma * 65536 + chroma_term) >>> 16;
      if (s < 0) return 8'd0;
      if (s > 255) return 8'd255;
      return s[7:0];
    endfunction

    function void note_macropixel(logic [7:0] y0, logic [7:0] u, logic [7:0] y1,
                                  logic [7:0] v);
      int w, h, c, r, ur, vr;
      bgr_pair_t p;
      // zero counts as one, oversize saturates
      w = (width_reg == 0) ? 1 : int'(width_reg);
      if (w > MAX_WIDTH / 2) w = MAX_WIDTH / 2;
      if (w > COL_CAP) w = COL_CAP;
      h = (height_reg == 0) ? 1 : int'(height_reg);
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      if (h > ROW_CAP) h = ROW_CAP;
      // counters beyond a shrunken size clamp to the last position
      c = (col >= w) ? w - 1 : col;
      r = (row >= h) ? h - 1 : row;
      ur = int'(u) - 128;
      vr = int'(v) - 128;
      p.dest   = 22'((h - 1 - r) * 2 * w + 2 * c);
      p.blue0  = shade(int'(y0), int'(KB) * ur);
      p.green0 = shade(int'(y0), -(int'(KGU) * ur) - int'(KGV) * vr);
      p.red0   = shade(int'(y0), int'(KR) * vr);
      p.blue1  = shade(int'(y1), int'(KB) * ur);
      p.green1 = shade(int'(y1), -(int'(KGU) * ur) - int'(KGV) * vr);
      p.red1   = shade(int'(y1), int'(KR) * vr);
      p.row_end   = (col + 1 >= w);
      p.frame_end = p.row_end && (row + 1 >= h);
      // advance the raster position
      if (p.row_end) begin
        col = 0;
        row = p.frame_end ? 0 : (row + 1) & 'h7FF;
      end else begin
        col = (col + 1) & 'h3FF;
      end
      expected_pairs.push_back(p);
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task compare(string field, int unsigned got, int unsigned want);
      if (got != want)
        report($sformatf("beat %0d %s: got %0d, expected %0d", beats_out, field, got, want));
    endtask

    task check_pair(bgr_pair_t got);
      bgr_pair_t want;
      beats_out++;
      if (expected_pairs.size() == 0) begin
        report($sformatf("beat %0d arrived with nothing expected", beats_out));
        return;
      end
      want = expected_pairs.pop_front();
      compare("dest_pixel_index", got.dest, want.dest);
      compare("blue_first", got.blue0, want.blue0);
      compare("green_first", got.green0, want.green0);
      compare("red_first", got.red0, want.red0);
      compare("blue_second", got.blue1, want.blue1);
      compare("green_second", got.green1, want.green1);
      compare("red_second", got.red1, want.red1);
      compare("row_end", got.row_end, want.row_end);
      compare("frame_end", got.frame_end, want.frame_end);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = REG_WIDTH_PAIRS;
  logic [11:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  luma_first = '0;
  logic [7:0]  chroma_blue = '0;
  logic [7:0]  luma_second = '0;
  logic [7:0]  chroma_red = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [21:0] dest_pixel_index;
  logic [7:0]  blue_first, green_first, red_first;
  logic [7:0]  blue_second, green_second, red_second;
  logic        row_end, frame_end;

  pair_scoreboard sb;
  int gap_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  // Corner macropixels {Y0, U, Y1, V}: black/white, full chroma swings, gray
  logic [31:0] corner_pixels [N_CORNERS] = '{
    32'h00000000, 32'hFFFFFFFF, 32'h0080FF80, 32'hFF0000FF,
    32'h00FFFF00, 32'h80808080, 32'h1080EB80, 32'hFF00FF00,
    32'h00FF00FF, 32'hEBF01010, 32'h017FFE81, 32'h7F0180FE
  };

  // Size per phase: collapsed, tiny, shrink mid-frame, largest, oversize
  logic [11:0] phase_width  [N_PHASES] = '{12'd0, 12'd3, 12'd1, 12'd7, 12'd2,
                                           12'd1024, 12'hFFF, 12'd300, 12'd5, 12'd1};
  logic [11:0] phase_height [N_PHASES] = '{12'd0, 12'd2, 12'd5, 12'd4, 12'd2,
                                           12'd2048, 12'hFFF, 12'd2, 12'd1, 12'd1};
  int phase_beats [N_PHASES] = '{60, 200, 150, 213, 150, 250, 100, 330, 200, 60};
  int gap_by_mode   [4] = '{0, 61, 0, 16};
  int stall_by_mode [4] = '{0, 0, 61, 16};

  yuyv_to_bgr_bottom_up #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .luma_first      (luma_first),
    .chroma_blue     (chroma_blue),
    .luma_second     (luma_second),
    .chroma_red      (chroma_red),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .dest_pixel_index(dest_pixel_index),
    .blue_first      (blue_first),
    .green_first     (green_first),
    .red_first       (red_first),
    .blue_second     (blue_second),
    .green_second    (green_second),
    .red_second      (red_second),
    .row_end         (row_end),
    .frame_end       (frame_end)
  );

  always #1 clk = ~clk;

  // Result side: random back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Check every accepted result beat
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_pair({dest_pixel_index, blue_first, green_first, red_first,
                     blue_second, green_second, red_second, row_end, frame_end});
  end

  // Watchdog: no beat on either side for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Mostly random bytes, with the extremes and mid-scale mixed in
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(15))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  // One input beat, after a random gap when the sender idles
  task automatic push_macropixel(input logic [7:0] y0, input logic [7:0] u,
                                 input logic [7:0] y1, input logic [7:0] v);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    luma_first  <= y0;
    chroma_blue <= u;
    luma_second <= y1;
    chroma_red  <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_macropixel(y0, u, y1, v);
  endtask

  // Stop sending and wait for every pending result
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_pairs.size() != 0) @(posedge clk);
  endtask

  // One register write beat; the caller lowers cfg_write
  task automatic cfg_beat(input logic [1:0] idx, input logic [11:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Resize while idle; optionally hit the unused indexes first
  task automatic program_size(input logic [11:0] w, input logic [11:0] h, input bit junk);
    drain_results();
    repeat (PIPE_CYCLES) @(posedge clk);
    if (junk) begin
      cfg_beat(REG_UNUSED, 12'hFFF);
      cfg_beat(REG_UNUSED_HI, 12'h001);
    end
    cfg_beat(REG_WIDTH_PAIRS, w);
    cfg_beat(REG_FRAME_HEIGHT, h);
    cfg_write <= 1'b0;
  endtask

  initial begin
    int p, i;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Corner colors at the reset size
    for (i = 0; i < N_CORNERS; i++)
      push_macropixel(corner_pixels[i][31:24], corner_pixels[i][23:16],
                      corner_pixels[i][15:8], corner_pixels[i][7:0]);

    // Random phases; sizes change with the counters left mid-frame
    for (p = 0; p < N_PHASES; p++) begin
      program_size(phase_width[p], phase_height[p], (p == 2));
      gap_pct   = gap_by_mode[p % 4];
      stall_pct = stall_by_mode[p % 4];
      for (i = 0; i < phase_beats[p]; i++) begin
        if (i == phase_beats[p] / 2) drain_results();
        push_macropixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());
      end
    end

    drain_results();
    repeat (PIPE_CYCLES) @(posedge clk);
    if (sb.expected_pairs.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_pairs.size()));
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
